FILE: design/arp_pkg.sv
// ----------------------------------------------------------------------------
// Arpeggiator package
// Shared types and fixed codes for the arpeggiator sequencer core.
// ----------------------------------------------------------------------------
package arp_pkg;

  // Play modes, as written into the mode register
  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_UPDOWN = 2'd2,
    MODE_RANDOM = 2'd3
  } arp_mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RB_READ,
    ST_RB_CALC,
    ST_RB_WRITE,
    ST_TICK_OUT,
    ST_MOD
  } arp_state_e;

  // Operation codes of an input item
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

  // Field widths
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned OUT_W    = 8;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned HELD_W   = 5;
  localparam int unsigned RND_W    = 16;
  localparam int unsigned OCT_W    = 3;
  localparam int unsigned SHIFT_W  = 7;
  localparam int unsigned RAISE_W  = 5;

  // Semitones per octave, and a reciprocal of it: floor(x * 171 / 2048)
  // equals floor(x / 12) for every x below 256
  localparam int unsigned OCTAVE      = 12;
  localparam int unsigned RECIP       = 171;
  localparam int unsigned RECIP_SHIFT = 11;

endpackage

FILE: design/arpeggiator_sequencer_core.sv
// ----------------------------------------------------------------------------
// Arpeggiator sequencer core
// Note pool, sequence store and a small sequencer that builds and plays
// an arpeggio in up, down, up-down or random order.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low; operation selects a pool write,
//   a rebuild of the sequence, or a clock tick. Mode, octave span and down
//   floor are written over the cfg_valid_i / cfg_ready_o channel, which is
//   always ready; write it only while busy is low.
//   Pool write: taken on accept, busy stays low.
//   Rebuild: busy for a pool read, then a calc and a write per step (steps =
//   held * (span + 1), up to the store depth); each entry takes one pass
//   through the pool read port and the shared add/reciprocal unit, then one
//   store write. Tick: the note shows on note_out_o with note_strobe_o for
//   one cycle, the cycle after transfer. Up, down and up-down modes then
//   free the block; random mode runs a bit-serial remainder over the 16-bit
//   random value and stays busy until it is done. A tick on an empty sequence
//   gives no result and busy stays low.
//   Reset clears position, step count, direction and configuration. The
//   store needs no clearing: every position a tick can read lies below the
//   largest step count ever built, so it was written.
//   The receiver cannot stall; each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module arpeggiator_sequencer_core
  import arp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 16,
  parameter int unsigned MAX_SPAN   = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [SLOT_W-1:0]     slot_index_i,
  input  logic [NOTE_W-1:0]     note_value_i,
  input  logic [HELD_W-1:0]     held_count_i,
  input  logic [RND_W-1:0]      random_value_i,
  output logic                  note_strobe_o,
  output logic [OUT_W-1:0]      note_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SEQ_DEPTH = POOL_DEPTH * (MAX_SPAN + 1);
  localparam int unsigned SC_W      = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned IDX_W     = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int unsigned HW        = $clog2(POOL_DEPTH + 1);
  localparam int unsigned PA_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  arp_state_e state_q, state_d;

  // configuration
  arp_mode_e           arp_mode_q;
  logic [1:0]          octave_span_q;
  logic [NOTE_W-1:0]   note_floor_q;

  // play state
  logic [SC_W-1:0]     position_q;
  logic [SC_W-1:0]     step_count_q;
  logic                descending_q;

  // rebuild walk
  logic [HW-1:0]       held_q;
  logic [HW-1:0]       rd_slot_q;
  logic [OCT_W-1:0]    span_q;
  logic [OCT_W-1:0]    oct_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [SHIFT_W-1:0]  off_q;
  logic [NOTE_W-1:0]   n_q;
  logic [RAISE_W-1:0]  raise_q;
  logic                last_q;
  logic [SC_W-1:0]     idx_q;

  // random remainder
  logic [RND_W-1:0]    rnd_q;
  logic [3:0]          bit_q;
  logic [SC_W-1:0]     rem_q;

  // memories
  logic [NOTE_W-1:0]   pool_mem [POOL_DEPTH];
  logic [NOTE_W-1:0]   pool_rdata_q;
  logic [OUT_W-1:0]    seq_mem  [SEQ_DEPTH];
  logic [OUT_W-1:0]    seq_rdata_q;

  logic accept;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Item decode
  // --------------------------------------------------------------------------
  logic [HW-1:0]    held_sat;
  logic [OCT_W-1:0] span_lim;
  logic             pool_we;

  assign held_sat = (32'(held_count_i) > POOL_DEPTH) ? HW'(POOL_DEPTH) : HW'(held_count_i);
  assign span_lim = (32'(octave_span_q) > MAX_SPAN) ? OCT_W'(MAX_SPAN) : OCT_W'(octave_span_q);
  assign pool_we  = accept && (operation_i == OP_WRITE) && (32'(slot_index_i) < POOL_DEPTH);

  // --------------------------------------------------------------------------
  // Shared unit: down-mode raise count and entry value
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0]   need;
  logic [OUT_W-1:0]   gap;
  logic [15:0]        prod;
  logic               below;
  logic [RAISE_W-1:0] raise_calc;
  logic [OUT_W:0]     raised;
  logic [OUT_W-1:0]   entry;

  assign need       = OUT_W'(note_floor_q) + OUT_W'(shift_q);
  assign below      = OUT_W'(pool_rdata_q) < need;
  assign gap        = need - OUT_W'(pool_rdata_q);
  assign prod       = (16'(gap) + 16'(OCTAVE - 1)) * 16'(RECIP);
  assign raise_calc = RAISE_W'(prod >> RECIP_SHIFT);
  assign raised     = (OUT_W + 1)'(n_q) + (OUT_W + 1)'({raise_q, 3'b000})
                    + (OUT_W + 1)'({raise_q, 2'b00});

  always_comb begin
    if (arp_mode_q == MODE_DOWN) begin
      entry = OUT_W'(raised - (OUT_W + 1)'(off_q));
    end else begin
      entry = OUT_W'(n_q) + OUT_W'(off_q);
    end
  end

  // remainder step: shift in one bit, subtract the step count if it fits
  logic [SC_W:0]   rem_trial;
  logic [SC_W-1:0] rem_next;

  assign rem_trial = {rem_q, rnd_q[bit_q]};
  assign rem_next  = (rem_trial >= {1'b0, step_count_q})
                   ? SC_W'(rem_trial - {1'b0, step_count_q}) : SC_W'(rem_trial);

  // tick advance for the non-random modes
  logic [SC_W-1:0] pos_inc;
  assign pos_inc = position_q + SC_W'(1);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_REBUILD && held_sat != '0) begin
            state_d = ST_RB_READ;
          end else if (operation_i == OP_TICK && step_count_q != '0) begin
            state_d = ST_TICK_OUT;
          end
        end
      end
      ST_RB_READ:  state_d = ST_RB_CALC;
      ST_RB_CALC:  state_d = ST_RB_WRITE;
      ST_RB_WRITE: state_d = last_q ? ST_IDLE : ST_RB_CALC;
      ST_TICK_OUT: state_d = (arp_mode_q == MODE_RANDOM) ? ST_MOD : ST_IDLE;
      ST_MOD:      state_d = (bit_q == 4'd0) ? ST_IDLE : ST_MOD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy          = (state_q != ST_IDLE);
    note_strobe_o = (state_q == ST_TICK_OUT);
    note_out_o    = seq_rdata_q;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      arp_mode_q    <= MODE_UP;
      octave_span_q <= '0;
      note_floor_q  <= '0;
      position_q    <= '0;
      step_count_q  <= '0;
      descending_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MODE:  arp_mode_q    <= arp_mode_e'(cfg_data_i[1:0]);
          CFG_SPAN:  octave_span_q <= cfg_data_i[1:0];
          CFG_FLOOR: note_floor_q  <= cfg_data_i;
          default:   ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept && operation_i == OP_REBUILD && held_sat == '0) begin
            step_count_q <= '0;
          end
        end
        ST_RB_WRITE: begin
          if (last_q) begin
            step_count_q <= idx_q + SC_W'(1);
          end
        end
        ST_TICK_OUT: begin
          case (arp_mode_q)
            MODE_UPDOWN: begin
              if (!descending_q) begin
                if (pos_inc >= step_count_q) begin
                  position_q   <= (step_count_q == SC_W'(1)) ? '0
                                : step_count_q - SC_W'(2);
                  descending_q <= 1'b1;
                end else begin
                  position_q <= pos_inc;
                end
              end else if (position_q == '0) begin
                position_q   <= (step_count_q == SC_W'(1)) ? '0 : SC_W'(1);
                descending_q <= 1'b0;
              end else begin
                position_q <= position_q - SC_W'(1);
              end
            end
            MODE_RANDOM: ;
            default: begin
              position_q <= (pos_inc >= step_count_q) ? '0 : pos_inc;
            end
          endcase
        end
        ST_MOD: begin
          if (bit_q == 4'd0) begin
            position_q <= rem_next;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        held_q    <= held_sat;
        rd_slot_q <= held_sat - HW'(1);
        span_q    <= span_lim;
        oct_q     <= '0;
        shift_q   <= '0;
        idx_q     <= '0;
        rnd_q     <= random_value_i;
      end
      ST_RB_CALC: begin
        n_q     <= pool_rdata_q;
        off_q   <= shift_q;
        raise_q <= (arp_mode_q == MODE_DOWN && below) ? raise_calc : '0;
        // walk slots from the highest held one down, then the next octave
        if (rd_slot_q == '0) begin
          rd_slot_q <= held_q - HW'(1);
          oct_q     <= oct_q + OCT_W'(1);
          shift_q   <= shift_q + SHIFT_W'(OCTAVE);
          last_q    <= (oct_q == span_q);
        end else begin
          rd_slot_q <= rd_slot_q - HW'(1);
          last_q    <= 1'b0;
        end
      end
      ST_RB_WRITE: begin
        idx_q <= idx_q + SC_W'(1);
      end
      ST_TICK_OUT: begin
        rem_q <= '0;
        bit_q <= 4'(RND_W - 1);
      end
      ST_MOD: begin
        rem_q <= rem_next;
        bit_q <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Note pool and sequence store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[PA_W'(slot_index_i)] <= note_value_i;
    end
    pool_rdata_q <= pool_mem[rd_slot_q[PA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RB_WRITE) begin
      seq_mem[idx_q[IDX_W-1:0]] <= entry;
    end
    seq_rdata_q <= seq_mem[position_q[IDX_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_strobe_o |=> !note_strobe_o)
    else $error("result strobe held for more than one cycle");

  a_empty_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_TICK && step_count_q == '0) |=> !busy)
    else $error("tick on empty sequence started work");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(position_q) < SEQ_DEPTH)
    else $error("position beyond sequence store");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RB_WRITE) |-> (32'(idx_q) < SEQ_DEPTH))
    else $error("rebuild writes beyond sequence store");

  a_steps_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK_OUT || state_q == ST_MOD) |=> $stable(step_count_q))
    else $error("step count changed during a tick");

endmodule
